>>> sv/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg: shared types and constants of the modem command sequencer
// State codes, command codes, event codes and the front-to-back event record.
// ----------------------------------------------------------------------------
package mcs_pkg;

	localparam int STEP_LIMIT_DEF = 8;
	localparam int TIMER_BITS_DEF = 16;

	localparam logic [15:0] BOOT_MS    = 16'd2000;
	localparam logic [15:0] RESET_MS   = 16'd100;
	localparam logic [15:0] QUIET_MS   = 16'd100;
	localparam logic [7:0]  UART_TX_MS = 8'd200;

	localparam logic [3:0] ST_OFFLINE  = 4'd0;
	localparam logic [3:0] ST_RECOVER  = 4'd1;
	localparam logic [3:0] ST_RESET    = 4'd2;
	localparam logic [3:0] ST_WAITBOOT = 4'd3;
	localparam logic [3:0] ST_SYNC     = 4'd4;
	localparam logic [3:0] ST_CONFIG   = 4'd5;
	localparam logic [3:0] ST_ARM      = 4'd6;
	localparam logic [3:0] ST_LISTEN   = 4'd7;
	localparam logic [3:0] ST_PROCESS  = 4'd8;
	localparam logic [3:0] ST_STOP     = 4'd9;
	localparam logic [3:0] ST_SEND     = 4'd10;
	localparam logic [3:0] ST_WAITTX   = 4'd11;

	localparam logic [1:0] CS_QUERY   = 2'd0;
	localparam logic [1:0] CS_SETMODE = 2'd1;
	localparam logic [1:0] CS_STOPRX  = 2'd2;
	localparam logic [1:0] CS_PARAMS  = 2'd3;

	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_SYNC    = 3'd1;
	localparam logic [2:0] CMD_GETMODE = 3'd2;
	localparam logic [2:0] CMD_SETMODE = 3'd3;
	localparam logic [2:0] CMD_STOPRX  = 3'd4;
	localparam logic [2:0] CMD_SETP2P  = 3'd5;
	localparam logic [2:0] CMD_RECV    = 3'd6;
	localparam logic [2:0] CMD_PSEND   = 3'd7;

	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_LINE  = 3'd1;
	localparam logic [2:0] MODE_BAD   = 3'd2;
	localparam logic [2:0] MODE_FAULT = 3'd3;
	localparam logic [2:0] MODE_FIX   = 3'd4;

	localparam logic [3:0] RC_OK      = 4'd0;
	localparam logic [3:0] RC_ERROR   = 4'd1;
	localparam logic [3:0] RC_BOOT    = 4'd2;
	localparam logic [3:0] RC_RXPKT   = 4'd3;
	localparam logic [3:0] RC_RXTMO   = 4'd4;
	localparam logic [3:0] RC_TXDONE  = 4'd5;
	localparam logic [3:0] RC_MODEP2P = 4'd6;
	localparam logic [3:0] RC_MODEOTH = 4'd7;

	localparam logic [2:0] REG_CONFIGURED = 3'd0;
	localparam logic [2:0] REG_CMD_TMO    = 3'd1;
	localparam logic [2:0] REG_TX_TMO     = 3'd2;
	localparam logic [2:0] REG_RX_WIN     = 3'd3;
	localparam logic [2:0] REG_BO_MIN     = 3'd4;
	localparam logic [2:0] REG_BO_MAX     = 3'd5;
	localparam logic [2:0] REG_RETRY      = 3'd6;
	localparam logic [2:0] REG_HEALTHY    = 3'd7;

	// one classified event, front to back
	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] reply_code;
		logic       tx_busy;
		logic       driver_ok;
		logic       frame_ok;
		logic       partial_line;
	} evt_t;

endpackage

>>> sv/mcs_front.sv
// ----------------------------------------------------------------------------
// mcs_front: input stage
// Accepts event requests into a two-entry queue for the sequencer core.
// ----------------------------------------------------------------------------
module mcs_front
	import mcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  evt_t       in_evt,
	output logic       q_valid,
	input  logic       q_pop,
	output evt_t       q_evt
);

	evt_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_evt    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_pop) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");

endmodule

>>> sv/mcs_core.sv
// ----------------------------------------------------------------------------
// mcs_core: sequencer back end
// Applies one event, then runs one sequencing step per cycle, and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module mcs_core
	import mcs_pkg::*;
#(
	parameter int STEP_LIMIT = STEP_LIMIT_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic       q_valid,
	output logic       q_pop,
	input  evt_t       q_evt,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] fsm_state,
	output logic [2:0] command,
	output logic [7:0] frame_seq,
	output logic       radio_reset,
	output logic       failed,
	output logic       timed_out,
	output logic       packet_received,
	output logic       frame_sent,
	output logic       reset_pulsed,
	output logic       link_healthy
);

	localparam int SC_W = $clog2(STEP_LIMIT + 1);
	localparam logic [SC_W-1:0] SC_MAX = SC_W'(STEP_LIMIT);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_STEP = 3'b010,
		S_OUT  = 3'b100
	} seq_t;

	// configuration
	logic                  configured_q;
	logic [15:0]           cmd_tmo_q, tx_tmo_q, rx_win_q, bo_min_q, bo_max_q, healthy_ms_q;
	logic [3:0]            retry_limit_q;

	// sequencer state
	seq_t                  seq_q;
	logic [3:0]            phase_q;
	logic [1:0]            cstep_q;
	logic [TIMER_BITS-1:0] dl_q;
	logic [7:0]            sdl_q;
	logic [15:0]           hage_q, backoff_q;
	logic [4:0]            retry_q;
	logic [7:0]            seqc_q;
	logic [SC_W-1:0]       sc_q;
	evt_t                  ev_q;
	// flags
	logic f_pend_q, f_ack_q, f_txres_q, f_mseen_q, f_mp2p_q, f_msw_q;
	logic f_rxend_q, f_infl_q, f_heal_q, f_fix_q;
	// item results
	logic [2:0] o_cmd_q;
	logic [7:0] o_seq_q;
	logic o_fail_q, o_tmo_q, o_pkt_q, o_sent_q, o_pulse_q;

	// next-state copies for the combinational step
	logic [3:0]            ph_n;
	logic [1:0]            cs_n;
	logic [TIMER_BITS-1:0] dl_n;
	logic [7:0]            sdl_n, seqc_n, oseq_n;
	logic [15:0]           hage_n, bo_n;
	logic [4:0]            rt_n;
	logic [2:0]            ocmd_n;
	logic p_n, a_n, t_n, ms_n, mp_n, sw_n, re_n, inf_n, h_n, fx_n;
	logic ofail_n, otmo_n, opkt_n, osent_n, opulse_n;
	logic cont_n;

	// event application
	logic [3:0]            e_ph;
	logic [1:0]            e_cs;
	logic [TIMER_BITS-1:0] e_dl;
	logic [7:0]            e_sdl;
	logic [15:0]           e_hage;
	logic e_p, e_a, e_t, e_ms, e_mp, e_re, e_inf, e_h, e_fx, e_fail, e_pkt;

	function automatic logic is_cmd_st(input logic [3:0] s);
		return s == ST_SYNC || s == ST_CONFIG || s == ST_ARM || s == ST_STOP ||
			s == ST_WAITTX;
	endfunction

	always_comb begin
		logic active, cst, do_fail;
		e_ph = phase_q; e_cs = cstep_q; e_dl = dl_q; e_sdl = sdl_q; e_hage = hage_q;
		e_p = f_pend_q; e_a = f_ack_q; e_t = f_txres_q; e_ms = f_mseen_q;
		e_mp = f_mp2p_q; e_re = f_rxend_q; e_inf = f_infl_q; e_h = f_heal_q;
		e_fx = f_fix_q; e_fail = 1'b0; e_pkt = 1'b0;
		do_fail = 1'b0;
		active = phase_q != ST_OFFLINE && phase_q != ST_RESET && phase_q != ST_RECOVER;
		cst = is_cmd_st(phase_q);
		case (q_evt.mode)
			MODE_TICK: begin
				if (dl_q != '0) e_dl = dl_q - 1'b1;
				if (sdl_q != '0) e_sdl = sdl_q - 1'b1;
				if (f_heal_q && hage_q != 16'hFFFF) e_hage = hage_q + 1'b1;
			end
			MODE_LINE: begin
				if (active && phase_q != ST_WAITBOOT) begin
					case (q_evt.reply_code)
						RC_BOOT: begin
							if (phase_q == ST_CONFIG && cstep_q == CS_SETMODE && f_pend_q)
								e_a = 1'b1;
							else do_fail = 1'b1;
						end
						RC_ERROR: do_fail = 1'b1;
						RC_RXPKT, RC_RXTMO: begin
							e_pkt = q_evt.reply_code == RC_RXPKT;
							if (phase_q == ST_ARM && f_pend_q) e_re = 1'b1;
							if (phase_q == ST_LISTEN) begin
								e_p = 1'b0; e_a = 1'b0; e_t = 1'b0; e_ms = 1'b0; e_re = 1'b0;
								if (q_evt.reply_code == RC_RXPKT) begin
									e_ph = ST_PROCESS; e_dl = '0;
								end else begin
									e_ph = ST_ARM; e_dl = TIMER_BITS'(cmd_tmo_q);
								end
							end
						end
						default: begin
							if (f_pend_q && cst) begin
								if (q_evt.reply_code == RC_OK) e_a = 1'b1;
								if (q_evt.reply_code == RC_TXDONE && phase_q == ST_WAITTX)
									e_t = 1'b1;
								if (phase_q == ST_CONFIG && cstep_q == CS_QUERY &&
									(q_evt.reply_code == RC_MODEP2P ||
									q_evt.reply_code == RC_MODEOTH)) begin
									e_ms = 1'b1;
									e_mp = q_evt.reply_code == RC_MODEP2P;
								end
							end
						end
					endcase
				end
			end
			MODE_BAD, MODE_FAULT: do_fail = active;
			MODE_FIX: e_fx = 1'b1;
			default: ;
		endcase
		if (do_fail) begin
			e_fail = 1'b1;
			if (e_inf) begin e_fx = 1'b1; e_inf = 1'b0; end
			e_h = 1'b0; e_ph = ST_RECOVER; e_dl = '0;
			e_p = 1'b0; e_a = 1'b0; e_t = 1'b0; e_ms = 1'b0; e_re = 1'b0;
		end
	end

	// one sequencing step from the registered state
	always_comb begin
		logic expired, f, ftmo, enter_en;
		logic [3:0] est;
		logic [TIMER_BITS-1:0] ems;
		logic [2:0] code;
		logic sub, sub_ok;
		logic [TIMER_BITS-1:0] sub_tmo;
		ph_n = phase_q; cs_n = cstep_q; dl_n = dl_q; sdl_n = sdl_q; seqc_n = seqc_q;
		oseq_n = o_seq_q; hage_n = hage_q; bo_n = backoff_q; rt_n = retry_q;
		ocmd_n = o_cmd_q;
		p_n = f_pend_q; a_n = f_ack_q; t_n = f_txres_q; ms_n = f_mseen_q; mp_n = f_mp2p_q;
		sw_n = f_msw_q; re_n = f_rxend_q; inf_n = f_infl_q; h_n = f_heal_q; fx_n = f_fix_q;
		ofail_n = o_fail_q; otmo_n = o_tmo_q; opkt_n = o_pkt_q; osent_n = o_sent_q;
		opulse_n = o_pulse_q;
		cont_n = 1'b0; f = 1'b0; ftmo = 1'b0; enter_en = 1'b0;
		est = phase_q; ems = '0; code = CMD_NONE; sub = 1'b0; sub_ok = 1'b1;
		sub_tmo = TIMER_BITS'(cmd_tmo_q);
		expired = dl_q == '0;
		if (f_heal_q && hage_q >= healthy_ms_q) begin
			rt_n = '0; bo_n = bo_min_q;
		end
		case (phase_q)
			ST_OFFLINE: begin
				if (configured_q && expired) begin
					rt_n = '0; sw_n = 1'b0;
					if (!ev_q.driver_ok) begin
						enter_en = 1'b1; est = ST_OFFLINE; ems = TIMER_BITS'(bo_n);
						bo_n = (bo_n < {1'b0, bo_max_q[15:1]}) ? {bo_n[14:0], 1'b0} : bo_max_q;
					end else begin
						enter_en = 1'b1; est = ST_WAITBOOT; ems = TIMER_BITS'(QUIET_MS);
					end
				end
			end
			ST_RECOVER: begin
				enter_en = 1'b1;
				if (!ev_q.driver_ok) begin
					est = ST_OFFLINE; ems = TIMER_BITS'(bo_n);
					bo_n = (bo_n < {1'b0, bo_max_q[15:1]}) ? {bo_n[14:0], 1'b0} : bo_max_q;
				end else if (rt_n < {1'b0, retry_limit_q}) begin
					rt_n = rt_n + 1'b1; est = ST_WAITBOOT; ems = TIMER_BITS'(QUIET_MS);
				end else begin
					if (rt_n != 5'd31) rt_n = rt_n + 1'b1;
					opulse_n = 1'b1; sw_n = 1'b0; est = ST_RESET; ems = TIMER_BITS'(RESET_MS);
				end
			end
			ST_RESET: begin
				if (expired) begin
					enter_en = 1'b1; est = ST_OFFLINE; ems = TIMER_BITS'(bo_n);
					bo_n = (bo_n < {1'b0, bo_max_q[15:1]}) ? {bo_n[14:0], 1'b0} : bo_max_q;
				end
			end
			ST_WAITBOOT: begin
				if (expired) begin
					enter_en = 1'b1; est = ST_SYNC; ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
				end
			end
			ST_PROCESS: begin
				enter_en = 1'b1; est = ST_ARM; ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
			end
			ST_LISTEN: begin
				if (f_fix_q) begin
					enter_en = 1'b1; est = ST_STOP; ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
				end else if (expired) begin
					enter_en = 1'b1; est = ST_ARM; ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
				end
			end
			ST_SEND: begin
				if (!f_fix_q) begin
					enter_en = 1'b1; est = ST_ARM; ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
				end else if (ev_q.tx_busy) begin
					if (expired) begin f = 1'b1; ftmo = 1'b1; end
				end else if (!ev_q.frame_ok) begin
					f = 1'b1;
				end else begin
					seqc_n = seqc_q + 1'b1;
					enter_en = 1'b1; est = ST_WAITTX; ems = TIMER_BITS'(tx_tmo_q);
					sub = 1'b1; code = CMD_PSEND; sub_tmo = TIMER_BITS'(tx_tmo_q);
				end
			end
			default: begin
				if (!is_cmd_st(phase_q)) begin
					f = 1'b1;
				end else if (f_pend_q) begin
					if (ev_q.tx_busy) begin
						if (sdl_q == '0) f = 1'b1;
						ftmo = f;
					end else begin
						logic done;
						done = 1'b0;
						if (f_ack_q) begin
							done = 1'b1;
							if (phase_q == ST_SYNC) begin
								cs_n = CS_QUERY; enter_en = 1'b1; est = ST_CONFIG;
								ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
							end else if (phase_q == ST_CONFIG) begin
								case (cstep_q)
									CS_QUERY: begin
										if (f_mseen_q) begin
											if (f_mp2p_q) begin
												cs_n = CS_STOPRX; enter_en = 1'b1; est = ST_CONFIG;
												ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
											end else if (f_msw_q) begin
												f = 1'b1;
											end else begin
												cs_n = CS_SETMODE; enter_en = 1'b1; est = ST_CONFIG;
												ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
											end
										end else done = 1'b0;
									end
									CS_SETMODE: begin
										enter_en = 1'b1; est = ST_WAITBOOT; ems = TIMER_BITS'(BOOT_MS);
									end
									CS_STOPRX: begin
										cs_n = CS_PARAMS; enter_en = 1'b1; est = ST_CONFIG;
										ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
									end
									default: begin
										enter_en = 1'b1; est = ST_ARM;
										ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
									end
								endcase
							end else if (phase_q == ST_ARM) begin
								if (!f_heal_q) begin h_n = 1'b1; hage_n = '0; end
								enter_en = 1'b1; est = f_rxend_q ? ST_ARM : ST_LISTEN;
								ems = f_rxend_q ? TIMER_BITS'(cmd_tmo_q) : TIMER_BITS'(rx_win_q);
								cont_n = 1'b1;
							end else if (phase_q == ST_STOP) begin
								enter_en = 1'b1; est = ST_SEND; ems = TIMER_BITS'(UART_TX_MS);
								cont_n = 1'b1;
							end else if (f_txres_q) begin
								inf_n = 1'b0; osent_n = 1'b1; enter_en = 1'b1; est = ST_ARM;
								ems = TIMER_BITS'(cmd_tmo_q); cont_n = 1'b1;
							end else done = 1'b0;
						end
						if (!done && expired) begin
							if (phase_q == ST_CONFIG && cstep_q == CS_SETMODE) begin
								enter_en = 1'b1; est = ST_WAITBOOT; ems = TIMER_BITS'(BOOT_MS);
							end else begin
								f = 1'b1; ftmo = 1'b1;
							end
						end
					end
				end else if (ev_q.tx_busy || ev_q.partial_line) begin
					if (expired) begin f = 1'b1; ftmo = 1'b1; end
				end else begin
					sub = 1'b1;
					case (phase_q)
						ST_SYNC: code = CMD_SYNC;
						ST_CONFIG: begin
							case (cstep_q)
								CS_QUERY: code = CMD_GETMODE;
								CS_SETMODE: begin code = CMD_SETMODE; sw_n = 1'b1; end
								CS_STOPRX: code = CMD_STOPRX;
								default: code = CMD_SETP2P;
							endcase
						end
						ST_ARM: code = CMD_RECV;
						ST_STOP: code = CMD_STOPRX;
						default: code = CMD_NONE;
					endcase
					sub_ok = code != CMD_NONE && ev_q.frame_ok;
				end
			end
		endcase
		if (enter_en) begin
			ph_n = est; dl_n = ems;
			p_n = 1'b0; a_n = 1'b0; t_n = 1'b0; ms_n = 1'b0; re_n = 1'b0;
		end
		if (sub) begin
			if (!sub_ok || !ev_q.driver_ok) begin
				f = 1'b1;
			end else begin
				p_n = 1'b1; a_n = 1'b0; t_n = 1'b0;
				dl_n = sub_tmo; sdl_n = UART_TX_MS; ocmd_n = code;
				if (code == CMD_PSEND) begin
					oseq_n = seqc_q; inf_n = 1'b1; fx_n = 1'b0;
				end
			end
		end
		if (f) begin
			ofail_n = 1'b1;
			if (ftmo) otmo_n = 1'b1;
			if (inf_n) begin fx_n = 1'b1; inf_n = 1'b0; end
			h_n = 1'b0; ph_n = ST_RECOVER; dl_n = '0;
			p_n = 1'b0; a_n = 1'b0; t_n = 1'b0; ms_n = 1'b0; re_n = 1'b0;
			cont_n = 1'b1;
		end
	end

	assign q_pop = seq_q == S_IDLE && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_IDLE;
			configured_q <= 1'b0;
			cmd_tmo_q <= 16'd500; tx_tmo_q <= 16'd500; rx_win_q <= 16'd3000;
			bo_min_q <= 16'd5000; bo_max_q <= 16'd60000; retry_limit_q <= 4'd3;
			healthy_ms_q <= 16'd30000;
			phase_q <= ST_OFFLINE; cstep_q <= CS_QUERY; dl_q <= '0; sdl_q <= '0;
			hage_q <= '0; backoff_q <= 16'd5000; retry_q <= '0; seqc_q <= '0;
			sc_q <= '0;
			f_pend_q <= 1'b0; f_ack_q <= 1'b0; f_txres_q <= 1'b0; f_mseen_q <= 1'b0;
			f_mp2p_q <= 1'b0; f_msw_q <= 1'b0; f_rxend_q <= 1'b0; f_infl_q <= 1'b0;
			f_heal_q <= 1'b0; f_fix_q <= 1'b0;
			o_cmd_q <= CMD_NONE; o_seq_q <= '0; o_fail_q <= 1'b0; o_tmo_q <= 1'b0;
			o_pkt_q <= 1'b0; o_sent_q <= 1'b0; o_pulse_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_CONFIGURED: configured_q <= cfg_data[0];
					REG_CMD_TMO: cmd_tmo_q <= cfg_data;
					REG_TX_TMO: tx_tmo_q <= cfg_data;
					REG_RX_WIN: rx_win_q <= cfg_data;
					REG_BO_MIN: begin bo_min_q <= cfg_data; backoff_q <= cfg_data; end
					REG_BO_MAX: bo_max_q <= cfg_data;
					REG_RETRY: retry_limit_q <= cfg_data[3:0];
					REG_HEALTHY: healthy_ms_q <= cfg_data;
					default: ;
				endcase
			end
			case (seq_q)
				S_IDLE: begin
					if (q_valid) begin
						ev_q <= q_evt;
						phase_q <= e_ph; cstep_q <= e_cs; dl_q <= e_dl; sdl_q <= e_sdl;
						hage_q <= e_hage;
						f_pend_q <= e_p; f_ack_q <= e_a; f_txres_q <= e_t; f_mseen_q <= e_ms;
						f_mp2p_q <= e_mp; f_rxend_q <= e_re; f_infl_q <= e_inf; f_heal_q <= e_h;
						f_fix_q <= e_fx;
						o_cmd_q <= CMD_NONE; o_seq_q <= '0; o_fail_q <= e_fail; o_tmo_q <= 1'b0;
						o_pkt_q <= e_pkt; o_sent_q <= 1'b0; o_pulse_q <= 1'b0;
						sc_q <= '0;
						seq_q <= S_STEP;
					end
				end
				S_STEP: begin
					phase_q <= ph_n; cstep_q <= cs_n; dl_q <= dl_n; sdl_q <= sdl_n;
					hage_q <= hage_n; backoff_q <= bo_n; retry_q <= rt_n; seqc_q <= seqc_n;
					f_pend_q <= p_n; f_ack_q <= a_n; f_txres_q <= t_n; f_mseen_q <= ms_n;
					f_mp2p_q <= mp_n; f_msw_q <= sw_n; f_rxend_q <= re_n; f_infl_q <= inf_n;
					f_heal_q <= h_n; f_fix_q <= fx_n;
					o_cmd_q <= ocmd_n; o_seq_q <= oseq_n; o_fail_q <= ofail_n; o_tmo_q <= otmo_n;
					o_pkt_q <= opkt_n; o_sent_q <= osent_n; o_pulse_q <= opulse_n;
					sc_q <= sc_q + 1'b1;
					if (!cont_n || sc_q + 1'b1 == SC_MAX) seq_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) seq_q <= S_IDLE;
				end
				default: seq_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = seq_q == S_OUT;
	assign fsm_state       = phase_q;
	assign command         = o_cmd_q;
	assign frame_seq       = o_seq_q;
	assign radio_reset     = phase_q == ST_RESET;
	assign failed          = o_fail_q;
	assign timed_out       = o_tmo_q;
	assign packet_received = o_pkt_q;
	assign frame_sent      = o_sent_q;
	assign reset_pulsed    = o_pulse_q;
	assign link_healthy    = f_heal_q;

	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == S_STEP |-> sc_q < SC_MAX)
		else $error("step count overrun");
	a_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!o_tmo_q || o_fail_q))
		else $error("timeout without failure");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(phase_q))
		else $error("result changed while stalled");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> seq_q == S_STEP)
		else $error("event popped without stepping");

endmodule

>>> sv/modem_command_sequencer.sv
// ----------------------------------------------------------------------------
// modem_command_sequencer: radio modem control sequencer
// Event requests go through a short queue to a core that steps the modem
// state machine and reports one result per event.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   in       | in_valid / in_ready    | mode, reply_code, status bits
//   out      | out_valid / out_ready  | fsm_state, command, event flags
//   cfg      | cfg_we                 | cfg_idx, cfg_data
//
// In the core an event is first applied, then run for n steps (1 to
// STEP_LIMIT) one per cycle, then the result register waits for out_ready.
// The two-entry input queue keeps taking requests while the core works, until it is full.
// Reset leaves the modem offline with default settings.
// ----------------------------------------------------------------------------
module modem_command_sequencer
	import mcs_pkg::*;
#(
	parameter int STEP_LIMIT = STEP_LIMIT_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [3:0]  reply_code,
	input  logic        tx_busy,
	input  logic        driver_ok,
	input  logic        frame_ok,
	input  logic        partial_line,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  fsm_state,
	output logic [2:0]  command,
	output logic [7:0]  frame_seq,
	output logic        radio_reset,
	output logic        failed,
	output logic        timed_out,
	output logic        packet_received,
	output logic        frame_sent,
	output logic        reset_pulsed,
	output logic        link_healthy
);

	evt_t in_evt, q_evt;
	logic q_valid, q_pop;

	assign in_evt = '{mode: mode, reply_code: reply_code, tx_busy: tx_busy,
		driver_ok: driver_ok, frame_ok: frame_ok, partial_line: partial_line};

	mcs_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_evt(in_evt), .q_valid(q_valid), .q_pop(q_pop), .q_evt(q_evt)
	);

	mcs_core #(.STEP_LIMIT(STEP_LIMIT), .TIMER_BITS(TIMER_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .q_valid(q_valid), .q_pop(q_pop), .q_evt(q_evt),
		.out_valid(out_valid), .out_ready(out_ready), .fsm_state(fsm_state),
		.command(command), .frame_seq(frame_seq), .radio_reset(radio_reset),
		.failed(failed), .timed_out(timed_out), .packet_received(packet_received),
		.frame_sent(frame_sent), .reset_pulsed(reset_pulsed),
		.link_healthy(link_healthy)
	);

endmodule

>>> bench/modem_command_sequencer_test.sv
// ----------------------------------------------------------------------------
// modem_command_sequencer_test: self-checking bench for the modem sequencer
// A behavioral model of the sequencer steers the stimulus toward replies the
// modem would send, predicts one result per event request and checks every
// result field against it. Both sides stall at random in the earlier phases,
// and once the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module modem_command_sequencer_test;
	import mcs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// model flag bits
	localparam int F_PENDING  = 0;
	localparam int F_ACK      = 1;
	localparam int F_TXRES    = 2;
	localparam int F_MSEEN    = 3;
	localparam int F_MP2P     = 4;
	localparam int F_MSWITCH  = 5;
	localparam int F_RXEND    = 6;
	localparam int F_INFLIGHT = 7;
	localparam int F_HEALTHY  = 8;
	localparam int F_FIX      = 9;

	localparam int IDLE_SENDER_LIGHT = 0;
	localparam int IDLE_SENDER_HEAVY = 1;
	localparam int IDLE_NONE         = 2;

	typedef struct packed {
		logic [3:0] st;
		logic [2:0] cmd;
		logic [7:0] seq;
		logic       rst_line;
		logic       fl;
		logic       tmo;
		logic       pkt;
		logic       sent;
		logic       pulse;
		logic       healthy;
	} result_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_idx = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [2:0]  mode = '0;
	logic [3:0]  reply_code = '0;
	logic        tx_busy = 0;
	logic        driver_ok = 0;
	logic        frame_ok = 0;
	logic        partial_line = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [3:0]  fsm_state;
	logic [2:0]  command;
	logic [7:0]  frame_seq;
	logic        radio_reset, failed, timed_out, packet_received;
	logic        frame_sent, reset_pulsed, link_healthy;

	modem_command_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .reply_code(reply_code), .tx_busy(tx_busy),
		.driver_ok(driver_ok), .frame_ok(frame_ok), .partial_line(partial_line),
		.out_valid(out_valid), .out_ready(out_ready),
		.fsm_state(fsm_state), .command(command), .frame_seq(frame_seq),
		.radio_reset(radio_reset), .failed(failed), .timed_out(timed_out),
		.packet_received(packet_received), .frame_sent(frame_sent),
		.reset_pulsed(reset_pulsed), .link_healthy(link_healthy)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	evt_t    request_q[$];
	result_t status_q[$];
	int      errors = 0;
	int      idle_mode = IDLE_SENDER_LIGHT;
	bit      hold_req = 0;

	// ---------------- sequencer model ----------------
	bit          m_on;
	logic [15:0] m_cmd_tmo, m_tx_tmo, m_rx_win, m_bo_min, m_bo_max, m_healthy_ms;
	logic [3:0]  m_retry_lim;
	logic [3:0]  ph;
	logic [1:0]  cstep;
	logic [15:0] dl, hage, bo;
	logic [7:0]  sdl, seq;
	logic [4:0]  rcnt;
	logic [9:0]  flags;
	bit          e_busy, e_drv, e_frame, e_part;
	result_t     cur;

	function void model_reset();
		m_on = 0; m_cmd_tmo = 500; m_tx_tmo = 500; m_rx_win = 3000;
		m_bo_min = 5000; m_bo_max = 60000; m_retry_lim = 3; m_healthy_ms = 30000;
		ph = ST_OFFLINE; cstep = CS_QUERY; dl = 0; sdl = 0; hage = 0;
		bo = 5000; rcnt = 0; seq = 0; flags = '0;
	endfunction

	function void model_cfg(logic [2:0] idx, logic [15:0] v);
		case (idx)
			REG_CONFIGURED: m_on = v[0];
			REG_CMD_TMO: m_cmd_tmo = v;
			REG_TX_TMO: m_tx_tmo = v;
			REG_RX_WIN: m_rx_win = v;
			REG_BO_MIN: begin
				m_bo_min = v;
				bo = v;
			end
			REG_BO_MAX: m_bo_max = v;
			REG_RETRY: m_retry_lim = v[3:0];
			REG_HEALTHY: m_healthy_ms = v;
			default: ;
		endcase
	endfunction

	function void enter(logic [3:0] st, logic [15:0] ms);
		ph = st;
		dl = ms;
		flags[F_PENDING] = 0; flags[F_ACK] = 0; flags[F_TXRES] = 0;
		flags[F_MSEEN] = 0; flags[F_RXEND] = 0;
	endfunction

	function void fail(bit tmo);
		cur.fl = 1;
		if (tmo) cur.tmo = 1;
		if (flags[F_INFLIGHT]) begin
			flags[F_FIX] = 1;
			flags[F_INFLIGHT] = 0;
		end
		flags[F_HEALTHY] = 0;
		enter(ST_RECOVER, 0);
	endfunction

	function void drop_offline();
		enter(ST_OFFLINE, bo);
		if (bo < m_bo_max / 2) bo = {bo[14:0], 1'b0};
		else bo = m_bo_max;
	endfunction

	function bit cmd_state(logic [3:0] st);
		return st == ST_SYNC || st == ST_CONFIG || st == ST_ARM ||
			st == ST_STOP || st == ST_WAITTX;
	endfunction

	function void goto_cfg_step(logic [1:0] s);
		cstep = s;
		enter(ST_CONFIG, m_cmd_tmo);
	endfunction

	function bit submit(bit ok_len, logic [2:0] code, logic [15:0] tmo);
		if (!ok_len || !e_drv) begin
			fail(0);
			return 0;
		end
		flags[F_PENDING] = 1; flags[F_ACK] = 0; flags[F_TXRES] = 0;
		dl = tmo;
		sdl = UART_TX_MS;
		cur.cmd = code;
		return 1;
	endfunction

	function void take_reply(logic [3:0] r);
		if (ph == ST_OFFLINE || ph == ST_RECOVER || ph == ST_RESET ||
			ph == ST_WAITBOOT) return;
		if (r == RC_BOOT) begin
			if (ph == ST_CONFIG && cstep == CS_SETMODE && flags[F_PENDING]) flags[F_ACK] = 1;
			else fail(0);
			return;
		end
		if (r == RC_ERROR) begin
			fail(0);
			return;
		end
		if (r == RC_RXPKT || r == RC_RXTMO) begin
			if (r == RC_RXPKT) cur.pkt = 1;
			if (ph == ST_ARM && flags[F_PENDING]) flags[F_RXEND] = 1;
			if (ph == ST_LISTEN) begin
				if (r == RC_RXPKT) enter(ST_PROCESS, 0);
				else enter(ST_ARM, m_cmd_tmo);
			end
			return;
		end
		if (!flags[F_PENDING] || !cmd_state(ph)) return;
		if (r == RC_OK) flags[F_ACK] = 1;
		if (r == RC_TXDONE && ph == ST_WAITTX) flags[F_TXRES] = 1;
		if (ph == ST_CONFIG && cstep == CS_QUERY && (r == RC_MODEP2P || r == RC_MODEOTH)) begin
			flags[F_MSEEN] = 1;
			flags[F_MP2P] = (r == RC_MODEP2P);
		end
	endfunction

	function bit run_step();
		bit expired;
		logic [7:0] sq;
		logic [2:0] code;
		expired = (dl == 0);
		if (flags[F_HEALTHY] && hage >= m_healthy_ms) begin
			rcnt = 0;
			bo = m_bo_min;
		end
		case (ph)
			ST_OFFLINE: begin
				if (!m_on || !expired) return 0;
				rcnt = 0;
				flags[F_MSWITCH] = 0;
				if (!e_drv) begin
					drop_offline();
					return 0;
				end
				enter(ST_WAITBOOT, QUIET_MS);
				return 0;
			end
			ST_RECOVER: begin
				if (!e_drv) begin
					drop_offline();
					return 0;
				end
				if (rcnt < m_retry_lim) begin
					rcnt++;
					enter(ST_WAITBOOT, QUIET_MS);
				end else begin
					if (rcnt < 31) rcnt++;
					cur.pulse = 1;
					flags[F_MSWITCH] = 0;
					enter(ST_RESET, RESET_MS);
				end
				return 0;
			end
			ST_RESET: begin
				if (expired) drop_offline();
				return 0;
			end
			ST_WAITBOOT: begin
				if (!expired) return 0;
				enter(ST_SYNC, m_cmd_tmo);
				return 1;
			end
			ST_PROCESS: begin
				enter(ST_ARM, m_cmd_tmo);
				return 1;
			end
			ST_LISTEN: begin
				if (flags[F_FIX]) enter(ST_STOP, m_cmd_tmo);
				else if (expired) enter(ST_ARM, m_cmd_tmo);
				else return 0;
				return 1;
			end
			ST_SEND: begin
				if (!flags[F_FIX]) begin
					enter(ST_ARM, m_cmd_tmo);
					return 1;
				end
				if (e_busy) begin
					if (expired) fail(1);
					return ph == ST_RECOVER;
				end
				if (!e_frame) begin
					fail(0);
					return 1;
				end
				sq = seq;
				seq = seq + 8'd1;
				enter(ST_WAITTX, m_tx_tmo);
				if (submit(1, CMD_PSEND, m_tx_tmo)) begin
					cur.seq = sq;
					flags[F_INFLIGHT] = 1;
					flags[F_FIX] = 0;
				end
				return ph == ST_RECOVER;
			end
			default: ;
		endcase

		if (!cmd_state(ph)) begin
			fail(0);
			return 1;
		end
		if (flags[F_PENDING]) begin
			if (e_busy) begin
				if (sdl == 0) begin
					fail(1);
					return 1;
				end
				return 0;
			end
			if (flags[F_ACK]) begin
				if (ph == ST_SYNC) begin
					goto_cfg_step(CS_QUERY);
					return 1;
				end
				if (ph == ST_CONFIG) begin
					if (cstep == CS_QUERY) begin
						if (flags[F_MSEEN]) begin
							if (flags[F_MP2P]) goto_cfg_step(CS_STOPRX);
							else if (flags[F_MSWITCH]) fail(0);
							else goto_cfg_step(CS_SETMODE);
							return 1;
						end
					end else if (cstep == CS_SETMODE) begin
						enter(ST_WAITBOOT, BOOT_MS);
						return 0;
					end else if (cstep == CS_STOPRX) begin
						goto_cfg_step(CS_PARAMS);
						return 1;
					end else begin
						enter(ST_ARM, m_cmd_tmo);
						return 1;
					end
				end else if (ph == ST_ARM) begin
					if (!flags[F_HEALTHY]) begin
						flags[F_HEALTHY] = 1;
						hage = 0;
					end
					if (flags[F_RXEND]) enter(ST_ARM, m_cmd_tmo);
					else enter(ST_LISTEN, m_rx_win);
					return 1;
				end else if (ph == ST_STOP) begin
					enter(ST_SEND, UART_TX_MS);
					return 1;
				end else if (flags[F_TXRES]) begin
					flags[F_INFLIGHT] = 0;
					cur.sent = 1;
					enter(ST_ARM, m_cmd_tmo);
					return 1;
				end
			end
			if (expired) begin
				if (ph == ST_CONFIG && cstep == CS_SETMODE) enter(ST_WAITBOOT, BOOT_MS);
				else fail(1);
				return ph == ST_RECOVER;
			end
			return 0;
		end

		if (e_busy || e_part) begin
			if (expired) begin
				fail(1);
				return 1;
			end
			return 0;
		end
		code = CMD_NONE;
		if (ph == ST_SYNC) code = CMD_SYNC;
		else if (ph == ST_CONFIG) begin
			if (cstep == CS_QUERY) code = CMD_GETMODE;
			else if (cstep == CS_SETMODE) begin
				flags[F_MSWITCH] = 1;
				code = CMD_SETMODE;
			end else if (cstep == CS_STOPRX) code = CMD_STOPRX;
			else code = CMD_SETP2P;
		end else if (ph == ST_ARM) code = CMD_RECV;
		else if (ph == ST_STOP) code = CMD_STOPRX;
		void'(submit(code != CMD_NONE && e_frame, code, m_cmd_tmo));
		return ph == ST_RECOVER;
	endfunction

	function result_t predict_status(evt_t e);
		bit active;
		cur = '0;
		e_busy = e.tx_busy; e_drv = e.driver_ok; e_frame = e.frame_ok; e_part = e.partial_line;
		active = ph != ST_OFFLINE && ph != ST_RESET && ph != ST_RECOVER;
		if (e.mode == MODE_TICK) begin
			if (dl != 0) dl--;
			if (sdl != 0) sdl--;
			if (flags[F_HEALTHY] && hage != 16'hFFFF) hage++;
		end else if (e.mode == MODE_LINE) begin
			if (active) take_reply(e.reply_code);
		end else if (e.mode == MODE_BAD || e.mode == MODE_FAULT) begin
			if (active) fail(0);
		end else if (e.mode == MODE_FIX) flags[F_FIX] = 1;
		for (int i = 0; i < STEP_LIMIT_DEF; i++)
			if (!run_step()) break;
		cur.st = ph;
		cur.rst_line = (ph == ST_RESET);
		cur.healthy = flags[F_HEALTHY];
		return cur;
	endfunction

	// ---------------- stimulus ----------------
	function bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function void queue_request(evt_t e);
		request_q.push_back(e);
		status_q.push_back(predict_status(e));
	endfunction

	function void queue_raw(logic [2:0] md, logic [3:0] rc, logic [3:0] bits);
		evt_t e;
		e.mode = md; e.reply_code = rc;
		{e.tx_busy, e.driver_ok, e.frame_ok, e.partial_line} = bits;
		queue_request(e);
	endfunction

	// reply the modem would plausibly give in the current state
	function logic [3:0] likely_reply();
		case (ph)
			ST_CONFIG: begin
				if (cstep == CS_QUERY && !flags[F_MSEEN])
					return chance(75) ? RC_MODEP2P : RC_MODEOTH;
				if (cstep == CS_SETMODE) return chance(60) ? RC_BOOT : RC_OK;
				return RC_OK;
			end
			ST_ARM: return chance(85) ? RC_OK : RC_RXPKT;
			ST_WAITTX: return flags[F_ACK] ? RC_TXDONE : RC_OK;
			default: return RC_OK;
		endcase
	endfunction

	task automatic gen_requests(int n);
		evt_t e;
		for (int k = 0; k < n; k++) begin
			e.tx_busy = chance(5);
			e.driver_ok = !chance(3);
			e.frame_ok = !chance(3);
			e.partial_line = chance(5);
			e.reply_code = RC_OK;
			e.mode = MODE_TICK;
			if (chance(8)) begin
				e = evt_t'(13'($urandom));
			end else if (chance(4)) begin
				e.mode = MODE_FIX;
			end else if (cmd_state(ph) && flags[F_PENDING] && !chance(15)) begin
				e.mode = MODE_LINE;
				e.reply_code = likely_reply();
			end else if (ph == ST_LISTEN) begin
				case ($urandom_range(5))
					0: begin
						e.mode = MODE_LINE;
						e.reply_code = RC_RXPKT;
					end
					1: begin
						e.mode = MODE_LINE;
						e.reply_code = RC_RXTMO;
					end
					2: e.mode = MODE_FIX;
					default: ;
				endcase
			end
			queue_request(e);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		model_cfg(idx, v);
	endtask

	task automatic wait_drained();
		wait (request_q.size() == 0 && status_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// ---------------- driver ----------------
	int   snd_idle, rcv_idle;
	evt_t next_req;

	always_comb begin
		case (idle_mode)
			IDLE_SENDER_LIGHT: begin
				snd_idle = 8;
				rcv_idle = 86;
			end
			IDLE_SENDER_HEAVY: begin
				snd_idle = 86;
				rcv_idle = 8;
			end
			default: begin
				snd_idle = 0;
				rcv_idle = 0;
			end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_ready) begin
			if (request_q.size() > 0 && !chance(snd_idle)) begin
				next_req = request_q.pop_front();
				in_valid <= 1;
				mode <= next_req.mode;
				reply_code <= next_req.reply_code;
				tx_busy <= next_req.tx_busy;
				driver_ok <= next_req.driver_ok;
				frame_ok <= next_req.frame_ok;
				partial_line <= next_req.partial_line;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// ---------------- receiver ----------------
	int hold_left = 0;
	bit hold_done = 0;

	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1;
			hold_left <= 400;
			out_ready <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else begin
			out_ready <= !chance(rcv_idle);
		end
	end

	// ---------------- monitor ----------------
	result_t got, want;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = {fsm_state, command, frame_seq, radio_reset, failed, timed_out,
				packet_received, frame_sent, reset_pulsed, link_healthy};
			if (status_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, got);
			end else begin
				want = status_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: result mismatch expected %p actual %p", $time, want, got);
				end
			end
		end
	end

	// ---------------- sequence ----------------
	initial begin
		model_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// not configured: everything stays offline, all modes and codes
		for (int c = 0; c < 16; c++)
			queue_raw(MODE_LINE, c[3:0], 4'b0100);
		for (int md = 0; md < 8; md++)
			queue_raw(md[2:0], 4'd15, 4'b1111);
		wait_drained();

		write_reg(REG_CONFIGURED, 16'd1);
		write_reg(REG_CMD_TMO, 16'd500);
		write_reg(REG_TX_TMO, 16'd500);
		write_reg(REG_RX_WIN, 16'd300);
		write_reg(REG_BO_MIN, 16'd5);
		write_reg(REG_BO_MAX, 16'd40);
		write_reg(REG_RETRY, 16'd3);
		write_reg(REG_HEALTHY, 16'd400);
		gen_requests(700);
		wait_drained();

		// minimum timing extremes, with a long transmit timeout
		idle_mode = IDLE_SENDER_HEAVY;
		write_reg(REG_RX_WIN, 16'd1);
		write_reg(REG_BO_MIN, 16'd1);
		write_reg(REG_BO_MAX, 16'd1);
		write_reg(REG_RETRY, 16'd0);
		write_reg(REG_HEALTHY, 16'd1);
		write_reg(REG_TX_TMO, 16'd60000);
		gen_requests(700);
		wait_drained();

		// maximum extremes; backoff reloaded to a short value afterwards
		idle_mode = IDLE_NONE;
		write_reg(REG_BO_MIN, 16'd60000);
		write_reg(REG_BO_MAX, 16'd60000);
		write_reg(REG_RETRY, 16'd15);
		write_reg(REG_HEALTHY, 16'd65535);
		write_reg(REG_RX_WIN, 16'd65535);
		write_reg(REG_CMD_TMO, 16'd60000);
		write_reg(REG_TX_TMO, 16'd500);
		write_reg(REG_BO_MIN, 16'd20);
		hold_req = 1;
		gen_requests(600);
		wait_drained();

		write_reg(REG_CONFIGURED, 16'd0);
		gen_requests(30);
		wait_drained();

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
